// ===== rtl/buddy_page_allocator_core_defines.svh =====
// Assertion helpers for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bpa check failed");
`define BPA_ASSERT_IMP(lbl, ante, cons) \
  `BPA_ASSERT(lbl, (ante) |-> (cons))
`else
`define BPA_ASSERT(lbl, prop)
`define BPA_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

  localparam int CntW = 11;
  localparam int OffW = 10;
  localparam int CfgW = 4;
  localparam int OrdW = 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_BAD_REQ   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DN_RD,
    S_DN_CHK,
    S_TGT_WR,
    S_UP_RD,
    S_UP_WR,
    S_FIN
  } state_e;

  typedef struct packed {
    logic            operation;
    logic [CntW-1:0] page_count;
    logic [OffW-1:0] page_offset;
  } in_req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [OffW-1:0] block_offset;
    logic [CntW-1:0] block_pages;
  } out_rsp_t;

endpackage

// ===== rtl/bpa_node_ram.sv =====
`include "buddy_page_allocator_core_defines.svh"

module bpa_node_ram #(
  parameter int Depth = 2047,
  parameter int AddrW = 11,
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

  // the walk never reads the entry it writes in the same cycle
  `BPA_ASSERT_IMP(a_no_rw_same, we_i && re_i, waddr_i != raddr_i)
  `BPA_ASSERT_IMP(a_waddr_range, we_i, waddr_i < AddrW'(Depth))
  `BPA_ASSERT_IMP(a_raddr_range, re_i, raddr_i < AddrW'(Depth))

endmodule

// ===== rtl/buddy_page_allocator_core.sv =====
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_stall_o   in_req_i  (operation, page_count, page_offset)
// out       out  out_valid_o / out_stall_i out_rsp_o (status, block_offset, block_pages)
// cfg       in   cfg_valid_i / cfg_ready_o cfg_data_i (pool_order)
//
// One request at a time. Alloc reads down the tree level by level, writes the target
// node and walks back up to the root; free writes the target and walks up; errors
// go straight to the result. The single node RAM port pair sets the rate: each level
// down is a read, then a check; each level up is a read, then a write.
// After reset and each cfg write a sweep rebuilds the tree; no request is taken during it.
// A result waits in the output register; a new request is taken meanwhile.
`include "buddy_page_allocator_core_defines.svh"

module buddy_page_allocator_core #(
  parameter int MAX_ORDER = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bpa_pkg::in_req_t            in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bpa_pkg::out_rsp_t           out_rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bpa_pkg::CfgW-1:0]    cfg_data_i
);
  import bpa_pkg::*;

  localparam int IW    = MAX_ORDER + 1;
  localparam int Nodes = (2 << MAX_ORDER) - 1;
  localparam int LW    = $clog2(MAX_ORDER + 2);
  localparam int PW    = $clog2(MAX_ORDER + 1);
  localparam int BW    = MAX_ORDER;
  localparam int RstOrder = (MAX_ORDER < 10) ? MAX_ORDER : 10;

  function automatic logic [LW-1:0] max_lv(logic [LW-1:0] a, logic [LW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  state_e          state_q, state_d;
  logic [PW-1:0]   po_q, po_d;
  logic [LW-1:0]   top_q, top_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [PW-1:0]   depth_q, depth_d;
  logic [LW-1:0]   lvl_q, lvl_d;
  logic [LW-1:0]   need_q, need_d;
  logic [LW-1:0]   maxn_q, maxn_d;
  logic [LW-1:0]   bs_q, bs_d;
  logic [OrdW-1:0] order_q, order_d;
  logic [BW-1:0]   base_q, base_d;
  logic            op_q, op_d;
  logic            side_q, side_d;
  out_rsp_t        res_q, res_d;
  logic            out_valid_q, out_valid_d;
  out_rsp_t        out_q, out_d;

  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  logic [2*LW-1:0] mem_wdata, mem_rdata;

  logic            in_acc, cfg_acc, out_free;
  logic [CntW-1:0] cnt_m1;
  logic [OrdW-1:0] req_order;
  logic [BW-1:0]   off_w, off_mask;
  logic [PW-1:0]   free_d;
  logic [IW-1:0]   free_idx;
  logic [IW:0]     init_last, init_next2, depth_lim;
  logic [LW-1:0]   init_val;
  logic [LW-1:0]   rd0, rd1, nw0, nw1;
  logic [IW-1:0]   par_idx;

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // order = ceil(log2(count)) = bit length of count-1
  always_comb begin
    cnt_m1    = in_req_i.page_count - CntW'(1);
    req_order = '0;
    for (int i = 0; i < CntW; i++) begin
      if (cnt_m1[i]) req_order = OrdW'(i + 1);
    end
  end

  always_comb begin
    off_w    = BW'({{BW{1'b0}}, in_req_i.page_offset});
    off_mask = (BW'(1) << po_q) - BW'(1);
    free_d   = po_q - PW'(req_order);
    free_idx = ((IW'(1) << free_d) - IW'(1)) + IW'((off_w & off_mask) >> req_order);
  end

  assign init_last  = ((IW + 1)'(2) << po_q) - (IW + 1)'(2);
  assign init_next2 = {1'b0, idx_q} + (IW + 1)'(2);
  assign depth_lim  = (IW + 1)'(2) << depth_q;
  assign init_val   = LW'(po_q - depth_q);

  assign rd0     = mem_rdata[LW-1:0];
  assign rd1     = mem_rdata[2*LW-1:LW];
  assign nw0     = side_q ? rd0 : maxn_q;
  assign nw1     = side_q ? maxn_q : rd1;
  assign par_idx = (idx_q - IW'(1)) >> 1;

  // next state and datapath
  always_comb begin
    state_d = state_q;
    po_d    = po_q;
    top_d   = top_q;
    idx_d   = idx_q;
    depth_d = depth_q;
    lvl_d   = lvl_q;
    need_d  = need_q;
    maxn_d  = maxn_q;
    bs_d    = bs_q;
    order_d = order_q;
    base_d  = base_q;
    op_d    = op_q;
    side_d  = side_q;
    res_d   = res_q;
    unique case (state_q)
      S_INIT: begin
        if ({1'b0, idx_q} == init_last) begin
          top_d   = LW'(po_q) + LW'(1);
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
          if (init_next2 == depth_lim) depth_d = depth_q + PW'(1);
        end
      end
      S_IDLE: begin
        if (cfg_acc) begin
          po_d    = ({1'b0, cfg_data_i} > 5'(MAX_ORDER)) ? PW'(MAX_ORDER) : PW'(cfg_data_i);
          idx_d   = '0;
          depth_d = '0;
          state_d = S_INIT;
        end else if (in_acc) begin
          op_d    = in_req_i.operation;
          order_d = req_order;
          res_d   = '0;
          state_d = S_FIN;
          if (in_req_i.page_count == '0) begin
            res_d.status = ST_BAD_REQ;
          end else if (6'(req_order) > 6'(po_q)) begin
            res_d.status = ST_NO_SPACE;
          end else if (in_req_i.operation == OP_ALLOC) begin
            need_d = LW'(req_order) + LW'(1);
            if (top_q < LW'(req_order) + LW'(1)) begin
              res_d.status = ST_NO_SPACE;
            end else begin
              res_d.block_pages = CntW'(1) << req_order;
              idx_d  = '0;
              lvl_d  = LW'(po_q) + LW'(1);
              base_d = '0;
              maxn_d = '0;
              state_d = (LW'(po_q) + LW'(1) > LW'(req_order) + LW'(1)) ? S_DN_RD : S_TGT_WR;
            end
          end else begin
            idx_d   = free_idx;
            maxn_d  = LW'(req_order) + LW'(1);
            bs_d    = LW'(req_order) + LW'(1);
            state_d = S_TGT_WR;
          end
        end
      end
      S_DN_RD: state_d = S_DN_CHK;
      S_DN_CHK: begin
        if (rd1 >= need_q || rd0 >= need_q) begin
          lvl_d = lvl_q - LW'(1);
          if (rd1 >= need_q) begin
            idx_d  = (idx_q << 1) + IW'(2);
            base_d = base_q + (BW'(1) << (lvl_q - LW'(2)));
          end else begin
            idx_d = (idx_q << 1) + IW'(1);
          end
          state_d = (lvl_q - LW'(1) > need_q) ? S_DN_RD : S_TGT_WR;
        end else begin
          res_d.status      = ST_NO_SPACE;
          res_d.block_pages = '0;
          state_d = S_FIN;
        end
      end
      S_TGT_WR: begin
        if (idx_q == '0) begin
          top_d   = maxn_q;
          state_d = S_FIN;
        end else begin
          state_d = S_UP_RD;
        end
        if (op_q == OP_ALLOC) res_d.block_offset = OffW'({{OffW{1'b0}}, base_q});
      end
      S_UP_RD: begin
        side_d  = ~idx_q[0];
        idx_d   = par_idx;
        state_d = S_UP_WR;
      end
      S_UP_WR: begin
        if (op_q == OP_ALLOC) begin
          maxn_d = max_lv(maxn_q, side_q ? rd0 : rd1);
        end else begin
          maxn_d = (nw0 == bs_q && nw1 == bs_q) ? bs_q + LW'(1) : max_lv(nw0, nw1);
          bs_d   = bs_q + LW'(1);
        end
        if (idx_q == '0) begin
          top_d   = (op_q == OP_ALLOC) ? max_lv(maxn_q, side_q ? rd0 : rd1)
                  : ((nw0 == bs_q && nw1 == bs_q) ? bs_q + LW'(1) : max_lv(nw0, nw1));
          state_d = S_FIN;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  // memory control and output register
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    unique case (state_q)
      S_INIT:   begin mem_we = 1'b1; mem_wdata = {init_val, init_val}; end
      S_DN_RD:  mem_re = 1'b1;
      S_TGT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (op_q == OP_ALLOC) ? '0 : {LW'(order_q), LW'(order_q)};
      end
      S_UP_RD:  begin mem_re = 1'b1; mem_raddr = par_idx; end
      S_UP_WR:  begin mem_we = 1'b1; mem_wdata = {nw1, nw0}; end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (state_q == S_FIN && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      po_q        <= PW'(RstOrder);
      top_q       <= '0;
      idx_q       <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      po_q        <= po_d;
      top_q       <= top_d;
      idx_q       <= idx_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    need_q  <= need_d;
    maxn_q  <= maxn_d;
    bs_q    <= bs_d;
    order_q <= order_d;
    base_q  <= base_d;
    op_q    <= op_d;
    side_q  <= side_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  bpa_node_ram #(
    .Depth (Nodes),
    .AddrW (IW),
    .DataW (2 * LW)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `BPA_ASSERT_IMP(a_load_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN)
  `BPA_ASSERT_IMP(a_fail_zero, out_valid_q && out_q.status != ST_OK,
                  out_q.block_pages == '0 && out_q.block_offset == '0)
  `BPA_ASSERT_IMP(a_desc_above_need, state_q == S_DN_CHK, lvl_q > need_q)
  `BPA_ASSERT_IMP(a_top_bound, state_q == S_IDLE, top_q <= LW'(po_q) + LW'(1))

endmodule

// ===== tb/buddy_page_allocator_core_checker.sv =====
module buddy_page_allocator_core_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  bpa_pkg::in_req_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  bpa_pkg::out_rsp_t out_rsp_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [3:0]        cfg_data_i,
  output int                pending_o,
  output int                errors_o,
  output int                grants_o
);
  import bpa_pkg::*;

  localparam int MaxOrd = 10;
  localparam int Nodes = (2 << MaxOrd) - 1;

  logic [7:0] left_lvl [Nodes];
  logic [7:0] right_lvl [Nodes];
  int unsigned pool_ord;
  int unsigned top_lvl;
  out_rsp_t grant_q[$];

  function automatic logic [7:0] max8(logic [7:0] a, logic [7:0] b);
    return a > b ? a : b;
  endfunction

  function automatic void rebuild_tree(int unsigned ord);
    int unsigned depth;
    depth = 0;
    pool_ord = ord > MaxOrd ? MaxOrd : ord;
    for (int i = 0; i < Nodes; i++) begin
      left_lvl[i] = '0;
      right_lvl[i] = '0;
    end
    for (int unsigned i = 0; i < (2 << pool_ord) - 1; i++) begin
      if (i + 1 >= (2 << depth)) depth++;
      left_lvl[i] = 8'(pool_ord - depth);
      right_lvl[i] = 8'(pool_ord - depth);
    end
    top_lvl = pool_ord + 1;
  endfunction

  // returns 1 on no_space
  function automatic bit grant_block(int unsigned need, output int unsigned base);
    int unsigned idx, lv, par;
    logic [7:0] maxn;
    idx = 0; lv = pool_ord + 1; base = 0; maxn = '0;
    if (top_lvl < need) return 1;
    while (lv > need && idx < Nodes) begin
      if (right_lvl[idx] >= need) begin
        idx = 2 * idx + 2;
        lv--;
        base += 1 << (lv - 1);
      end else if (left_lvl[idx] >= need) begin
        idx = 2 * idx + 1;
        lv--;
      end else begin
        break;
      end
    end
    if (lv > need || idx >= Nodes) return 1;
    left_lvl[idx] = '0;
    right_lvl[idx] = '0;
    while (idx > 0) begin
      par = (idx - 1) >> 1;
      if (idx & 1) begin
        left_lvl[par] = maxn;
        maxn = max8(maxn, right_lvl[par]);
      end else begin
        right_lvl[par] = maxn;
        maxn = max8(maxn, left_lvl[par]);
      end
      idx = par;
    end
    top_lvl = maxn;
    return 0;
  endfunction

  function automatic void release_block(int unsigned ord, int unsigned off);
    int unsigned idx, tot, half, par;
    logic [7:0] bs, maxn;
    idx = 0; tot = pool_ord;
    bs = 8'(ord + 1); maxn = bs;
    off &= (1 << pool_ord) - 1;
    while (tot > ord) begin
      half = 1 << (tot - 1);
      if (off < half) begin
        idx = 2 * idx + 1;
      end else begin
        idx = 2 * idx + 2;
        off -= half;
      end
      tot--;
    end
    if (idx >= Nodes) return;
    left_lvl[idx] = 8'(ord);
    right_lvl[idx] = 8'(ord);
    while (idx > 0) begin
      par = (idx - 1) >> 1;
      if (idx & 1) left_lvl[par] = maxn;
      else right_lvl[par] = maxn;
      if (left_lvl[par] == bs && right_lvl[par] == bs) maxn = 8'(bs + 1);
      else maxn = max8(left_lvl[par], right_lvl[par]);
      bs++;
      idx = par;
    end
    top_lvl = maxn;
  endfunction

  function automatic out_rsp_t serve_request(in_req_t r);
    out_rsp_t rsp;
    int unsigned ord, base;
    rsp = '0;
    ord = 0;
    if (r.page_count == 0) begin
      rsp.status = ST_BAD_REQ;
      return rsp;
    end
    while (ord < 12 && (1 << ord) < r.page_count) ord++;
    if (ord > pool_ord) begin
      rsp.status = ST_NO_SPACE;
      return rsp;
    end
    if (r.operation == OP_ALLOC) begin
      if (grant_block(ord + 1, base)) begin
        rsp.status = ST_NO_SPACE;
      end else begin
        rsp.block_offset = base[OffW-1:0];
        rsp.block_pages = CntW'(1 << ord);
      end
    end else begin
      release_block(ord, r.page_offset);
    end
    return rsp;
  endfunction

  initial rebuild_tree(10);

  assign pending_o = grant_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_rsp_t want;
    if (!rst_ni) begin
      errors_o <= 0;
      grants_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) rebuild_tree(cfg_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_rsp_i);
          errors_o <= errors_o + 1;
        end else begin
          want = grant_q.pop_front();
          if (want.status != out_rsp_i.status ||
              want.block_offset != out_rsp_i.block_offset ||
              want.block_pages != out_rsp_i.block_pages) begin
            $display("%0t: mismatch expected status=%0d off=%0d pages=%0d, got status=%0d off=%0d pages=%0d",
                     $time, want.status, want.block_offset, want.block_pages,
                     out_rsp_i.status, out_rsp_i.block_offset, out_rsp_i.block_pages);
            errors_o <= errors_o + 1;
          end
          if (want.status == ST_OK && want.block_pages != 0) grants_o <= grants_o + 1;
        end
      end
      if (in_valid_i && !in_stall_i) grant_q.push_back(serve_request(in_req_i));
    end
  end
endmodule

// ===== tb/buddy_page_allocator_core_test.sv =====
module buddy_page_allocator_core_test;
  import bpa_pkg::*;

  localparam int Watchdog = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  int pending, errors, grants;

  int gap_pct = 0;
  int stall_pct = 0;
  int cur_ord = 10;
  int idle_cycles = 0;
  int requests = 0;
  int cfg_writes = 0;
  logic [21:0] live_q[$];  // {offset, pages, 1'b0}

  always #2 clk_i = ~clk_i;

  buddy_page_allocator_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_rsp_o(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  buddy_page_allocator_core_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_rsp_i(out_rsp),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .pending_o(pending), .errors_o(errors), .grants_o(grants)
  );

  always @(posedge clk_i) begin
    if (rst_ni) out_stall <= ($urandom_range(99) < stall_pct);
    if (out_valid && !out_stall && out_rsp.status == ST_OK && out_rsp.block_pages != 0)
      live_q.push_back({out_rsp.block_offset, out_rsp.block_pages[10:0], 1'b0});
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Watchdog) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("buddy_page_allocator_core_test: FAIL");
      $finish;
    end
  end

  task automatic send(logic op, logic [10:0] cnt, logic [9:0] off);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= '{operation: op, page_count: cnt, page_offset: off};
    do @(posedge clk_i); while (in_stall);
    requests++;
  endtask

  task automatic write_order(logic [3:0] d);
    in_valid <= 1'b0;
    // let the checker see the last accepted request first
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    live_q.delete();
    cur_ord = d > 10 ? 10 : d;
    cfg_writes++;
  endtask

  task automatic random_request();
    int k, pick;
    logic [21:0] blk;
    if ($urandom_range(99) < 25) begin
      // noise: any field value
      send($urandom_range(1), $urandom_range(2047), $urandom_range(1023));
    end else if (live_q.size() != 0 && $urandom_range(99) < 45) begin
      pick = $urandom_range(live_q.size() - 1);
      blk = live_q[pick];
      live_q.delete(pick);
      send(OP_FREE, blk[11:1], blk[21:12]);
    end else begin
      k = $urandom_range(cur_ord < 4 ? cur_ord : 4);
      if ($urandom_range(9) == 0) k = $urandom_range(cur_ord);
      send(OP_ALLOC, $urandom_range((1 << k) / 2 + 1, 1 << k), $urandom_range(1023));
    end
  endtask

  logic [3:0] orders [8] = '{4'd10, 4'd0, 4'd3, 4'd10, 4'd5, 4'd15, 4'd1, 4'd7};

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // boundary requests on the reset pool
    send(OP_ALLOC, 0, 0);
    send(OP_FREE, 0, 1023);
    send(OP_ALLOC, 2047, 0);
    send(OP_FREE, 1025, 0);
    send(OP_ALLOC, 1024, 0);
    send(OP_ALLOC, 1, 0);
    send(OP_FREE, 1024, 1023);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 3, 0);
    send(OP_ALLOC, 512, 0);
    send(OP_FREE, 1, 1023);
    send(OP_FREE, 4, 1018);
    send(OP_ALLOC, 1024, 0);
    send(OP_FREE, 512, 0);       // frees the 512-page block granted at offset 0
    send(OP_ALLOC, 256, 0);
    send(OP_FREE, 1024, 0);
    write_order(0);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 2, 0);
    send(OP_FREE, 1, 1023);
    send(OP_ALLOC, 1, 0);
    for (int ph = 0; ph < 8; ph++) begin
      write_order(orders[ph]);
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 50; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 50; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      repeat (140) random_request();
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("%0d requests over %0d pool sizes, %0d blocks granted",
             requests, cfg_writes, grants);
    $display("idle mixes: none, sender gaps, output stalls, both");
    if (errors == 0) begin
      $display("buddy_page_allocator_core_test: PASS");
    end else begin
      $display("buddy_page_allocator_core_test: FAIL");
    end
    $finish;
  end
endmodule
